// ===== rtl/core/ccc_pkg.sv =====
// Shared types, codes and constants of the convex cell clearance block.
package ccc_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int MAX_CELLS_DEF    = 16;
    localparam int MAX_VERTICES_DEF = 8;

    localparam logic [1:0] CMD_VERTEX   = 2'd0;
    localparam logic [1:0] CMD_INTERVAL = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DISABLED = 2'd1;
    localparam logic [1:0] ST_NO_CELL  = 2'd2;
    localparam logic [1:0] ST_WRITE    = 2'd3;

    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_RADIUS    = 3'd1;
    localparam logic [2:0] REG_MARGIN    = 3'd2;
    localparam logic [2:0] REG_TOLERANCE = 3'd3;
    localparam logic [2:0] REG_CELLS     = 3'd4;

    localparam logic signed [31:0] CLEAR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CLEAR_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_VERTEX,
        OP_INTERVAL,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [3:0]         cell_index;
        logic [2:0]         vertex_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] interval_begin;
        logic signed [31:0] interval_end;
        logic [3:0]         vertex_count;
        logic signed [31:0] query_progress;
    } item_t;

    typedef struct packed {
        logic        region_enabled;
        logic [30:0] robot_radius;
        logic [30:0] safety_margin;
        logic [30:0] progress_tolerance;
        logic [4:0]  cells_in_use;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [3:0]         cnt;
    } cell_info_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_ARD0,
        S_ALD0,
        S_ARD,
        S_AMUL,
        S_AACC,
        S_ERD0,
        S_ELD0,
        S_ERD,
        S_EDIF,
        S_EM1,
        S_EM2,
        S_EM3,
        S_SQRT,
        S_DIVI,
        S_DIV,
        S_EACC,
        S_ENEXT,
        S_OUT
    } back_state_t;

endpackage

// ===== rtl/core/ccc_front.sv =====
// Front end: takes requests and classifies their commands for the queue.
module ccc_front import ccc_pkg::*; (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [3:0]         s_cell_index,
    input  logic [2:0]         s_vertex_index,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_interval_begin,
    input  logic signed [31:0] s_interval_end,
    input  logic [3:0]         s_vertex_count,
    input  logic signed [31:0] s_query_progress,
    input  logic               q_full,
    output logic               q_push,
    output item_t              q_item
);

    logic known;

    assign s_ready = !q_full;

    always_comb begin
        known     = 1'b1;
        q_item.op = OP_QUERY;
        unique case (s_command)
            CMD_VERTEX:   q_item.op = OP_VERTEX;
            CMD_INTERVAL: q_item.op = OP_INTERVAL;
            CMD_QUERY:    q_item.op = OP_QUERY;
            default:      known = 1'b0;
        endcase
        q_item.cell_index     = s_cell_index;
        q_item.vertex_index   = s_vertex_index;
        q_item.coord_x        = s_coord_x;
        q_item.coord_y        = s_coord_y;
        q_item.interval_begin = s_interval_begin;
        q_item.interval_end   = s_interval_end;
        q_item.vertex_count   = s_vertex_count;
        q_item.query_progress = s_query_progress;
    end

    // An unused command is taken and dropped; it produces no result.
    assign q_push = s_valid && !q_full && known;

endmodule

// ===== rtl/core/ccc_queue.sv =====
// Two-entry queue of classified requests between the front and back ends.
module ccc_queue import ccc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  pop_valid,
    output item_t pop_item
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !(pop && pop_valid)) begin
            count_next = count_reg + 2'd1;
        end else if (!push && pop && pop_valid) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && pop_valid) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/ccc_back.sv =====
// Back end: cell stores, cell search and the per-edge distance sequencer.
module ccc_back import ccc_pkg::*; #(
    parameter int MAX_CELLS    = MAX_CELLS_DEF,
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               q_valid,
    input  item_t              q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_clearance_value,
    output logic [1:0]         m_status
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;
    localparam int PW     = 2 * DW;
    localparam int AW     = PW + $clog2(MAX_VERTICES) + 1;
    localparam int RW     = PW + 1;
    localparam int SQW    = (RW + 1) / 2;
    localparam int DIVW   = SQW + 1;
    localparam int MW     = RW;
    localparam int QW     = CW + 3;
    localparam int BW     = QW + 3;
    localparam int KW     = $clog2(MW + 1);
    localparam int CIW    = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int VIW    = $clog2(MAX_VERTICES);
    localparam int NW     = $clog2(MAX_VERTICES + 1);
    localparam int CNTW   = $clog2(MAX_CELLS + 1);
    localparam int LW     = (CNTW > 5) ? CNTW : 5;
    localparam int VDEPTH = 2 ** (CIW + VIW);
    localparam int IDEPTH = 2 ** CIW;

    back_state_t state_reg, state_next;

    // Vertex store and cell information store, both with registered reads.
    logic [2*CW-1:0]      vmem [VDEPTH];
    logic [2*CW-1:0]      vrd_reg;
    logic                 vwe;
    logic [CIW+VIW-1:0]   vwaddr;
    logic [CIW+VIW-1:0]   vraddr;
    cell_info_t           imem [IDEPTH];
    cell_info_t           ird_reg;
    logic                 iwe;
    logic [CIW-1:0]       iwaddr;

    logic [LW-1:0]          c_reg;
    logic [NW-1:0]          n_reg;
    logic [NW-1:0]          i_reg;
    logic signed [CW-1:0]   px_reg, py_reg;
    logic signed [31:0]     prog_reg;
    logic signed [CW-1:0]   ax_reg, ay_reg;
    logic signed [DW-1:0]   dx_reg, dy_reg, ex_reg, ey_reg;
    logic signed [PW-1:0]   p1_reg, p2_reg;
    logic signed [AW-1:0]   area_reg;
    logic [RW-1:0]          len2_reg;
    logic signed [RW-1:0]   cross_reg;
    logic [2*SQW-1:0]       rad_reg;
    logic [SQW:0]           srem_reg;
    logic [SQW-1:0]         root_reg;
    logic [MW-1:0]          num_reg;
    logic [DIVW-1:0]        drem_reg;
    logic [QW-1:0]          q_reg;
    logic                   sat_reg;
    logic                   neg_reg;
    logic signed [BW-1:0]   best_reg;
    logic                   best_v_reg;
    logic [KW-1:0]          k_reg;
    logic signed [31:0]     res_val_reg;
    logic [1:0]             res_st_reg;

    logic [31:0]            ci_ext, vi_ext, nxt_ext, ncl_ext;
    logic                   cell_ok, vert_ok, last, start_query, hit;
    logic [LW-1:0]          lim;
    logic signed [CW-1:0]   bx, by;
    logic signed [DW-1:0]   ma1, mb1, ma2, mb2;
    logic signed [PW-1:0]   mp1, mp2;
    logic signed [33:0]     prog34, lo34, hi34;
    logic [SQW+2:0]         srem_s, trial, srem_d;
    logic                   sq_ge;
    logic [DIVW:0]          drs, dsub;
    logic                   dv_ge;
    logic [MW-1:0]          cross_mag;
    logic [QW-1:0]          q_clamped;
    logic signed [BW-1:0]   edge_dist, margin, infl;
    logic                   hi_ovf, lo_ovf;
    logic signed [31:0]     best_sat;

    assign bx = vrd_reg[2*CW-1:CW];
    assign by = vrd_reg[CW-1:0];

    assign ci_ext  = 32'(q_item.cell_index);
    assign vi_ext  = 32'(q_item.vertex_index);
    assign cell_ok = ci_ext < 32'(MAX_CELLS);
    assign vert_ok = vi_ext < 32'(MAX_VERTICES);
    assign start_query = q_valid && (q_item.op == OP_QUERY) && cfg.region_enabled;

    assign lim = (LW'(cfg.cells_in_use) < LW'(MAX_CELLS)) ? LW'(cfg.cells_in_use)
                                                         : LW'(MAX_CELLS);
    assign last    = (32'(i_reg) + 32'd1) == 32'(n_reg);
    assign nxt_ext = last ? 32'd0 : 32'(i_reg) + 32'd1;
    assign ncl_ext = (32'(ird_reg.cnt) > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES)
                                                            : 32'(ird_reg.cnt);

    // Interval match, widened by the tolerance on both sides.
    assign prog34 = {{2{prog_reg[31]}}, prog_reg};
    assign lo34   = {{2{ird_reg.lo[31]}}, ird_reg.lo} - {3'b000, cfg.progress_tolerance};
    assign hi34   = {{2{ird_reg.hi[31]}}, ird_reg.hi} + {3'b000, cfg.progress_tolerance};
    assign hit    = (prog34 >= lo34) && (prog34 <= hi34);

    assign mp1 = ma1 * mb1;
    assign mp2 = ma2 * mb2;

    // One bit of the integer square root per cycle.
    assign srem_s = {srem_reg, rad_reg[2*SQW-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge  = srem_s >= trial;
    assign srem_d = sq_ge ? srem_s - trial : srem_s;

    // One quotient bit of the restoring division per cycle.
    assign drs   = {drem_reg, num_reg[MW-1]};
    assign dv_ge = drs >= {2'b00, root_reg};
    assign dsub  = dv_ge ? drs - {2'b00, root_reg} : drs;

    assign cross_mag = cross_reg[RW-1] ? MW'(-cross_reg) : MW'(cross_reg);

    // A quotient that overflowed saturates the result either way, so a
    // clamp well above the 32-bit range gives the same answer.
    assign q_clamped = sat_reg ? (QW'(1) << (QW - 1)) : q_reg;
    assign infl      = BW'({1'b0, cfg.robot_radius}) + BW'({1'b0, cfg.safety_margin});
    assign edge_dist = (neg_reg != area_reg[AW-1]) ? -BW'({1'b0, q_clamped})
                                                   : BW'({1'b0, q_clamped});
    assign margin    = edge_dist - infl;

    assign hi_ovf   = best_reg > $signed({{(BW-32){1'b0}}, CLEAR_MAX});
    assign lo_ovf   = best_reg < $signed({{(BW-32){1'b1}}, CLEAR_MIN});
    assign best_sat = hi_ovf ? CLEAR_MAX : (lo_ovf ? CLEAR_MIN : best_reg[31:0]);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid) begin
                         state_next = start_query ? S_SRD : S_OUT;
                     end
            S_SRD:   state_next = (c_reg >= lim) ? S_OUT : S_SCMP;
            S_SCMP:  if (hit) begin
                         state_next = (ncl_ext == 32'd0) ? S_OUT : S_ARD0;
                     end else begin
                         state_next = S_SRD;
                     end
            S_ARD0:  state_next = S_ALD0;
            S_ALD0:  state_next = S_ARD;
            S_ARD:   state_next = S_AMUL;
            S_AMUL:  state_next = S_AACC;
            S_AACC:  state_next = last ? S_ERD0 : S_ARD;
            S_ERD0:  state_next = S_ELD0;
            S_ELD0:  state_next = S_ERD;
            S_ERD:   state_next = S_EDIF;
            S_EDIF:  state_next = S_EM1;
            S_EM1:   state_next = S_EM2;
            S_EM2:   state_next = S_EM3;
            S_EM3:   state_next = S_SQRT;
            S_SQRT:  if (k_reg == '0) begin
                         state_next = S_DIVI;
                     end
            S_DIVI:  state_next = (root_reg == '0) ? S_ENEXT : S_DIV;
            S_DIV:   if (k_reg == '0) begin
                         state_next = S_EACC;
                     end
            S_EACC:  state_next = S_ENEXT;
            S_ENEXT: state_next = last ? S_OUT : S_ERD;
            S_OUT:   if (m_ready) begin
                         state_next = S_IDLE;
                     end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        q_pop   = (state_reg == S_IDLE) && q_valid;
        m_valid = (state_reg == S_OUT);
        vwe     = q_pop && (q_item.op == OP_VERTEX) && cell_ok && vert_ok;
        iwe     = q_pop && (q_item.op == OP_INTERVAL) && cell_ok;
        vwaddr  = {ci_ext[CIW-1:0], vi_ext[VIW-1:0]};
        iwaddr  = ci_ext[CIW-1:0];
        vraddr  = {c_reg[CIW-1:0], nxt_ext[VIW-1:0]};
        ma1 = '0;
        mb1 = '0;
        ma2 = '0;
        mb2 = '0;
        unique case (state_reg)
            S_ARD0, S_ERD0: vraddr = {c_reg[CIW-1:0], {VIW{1'b0}}};
            S_AMUL: begin
                ma1 = {ax_reg[CW-1], ax_reg};
                mb1 = {by[CW-1], by};
                ma2 = {ay_reg[CW-1], ay_reg};
                mb2 = {bx[CW-1], bx};
            end
            S_EM1: begin
                ma1 = dx_reg;
                mb1 = dx_reg;
                ma2 = dy_reg;
                mb2 = dy_reg;
            end
            S_EM2: begin
                ma1 = dy_reg;
                mb1 = ex_reg;
                ma2 = dx_reg;
                mb2 = ey_reg;
            end
            default: ;
        endcase
    end

    assign m_clearance_value = res_val_reg;
    assign m_status          = res_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (vwe) begin
            vmem[vwaddr] <= {q_item.coord_x, q_item.coord_y};
        end
        vrd_reg <= vmem[vraddr];
        if (iwe) begin
            imem[iwaddr] <= '{lo: q_item.interval_begin, hi: q_item.interval_end,
                              cnt: q_item.vertex_count};
        end
        ird_reg <= imem[c_reg[CIW-1:0]];
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                px_reg   <= q_item.coord_x;
                py_reg   <= q_item.coord_y;
                prog_reg <= q_item.query_progress;
                c_reg    <= '0;
                if (q_item.op != OP_QUERY) begin
                    res_val_reg <= '0;
                    res_st_reg  <= ST_WRITE;
                end else begin
                    res_val_reg <= CLEAR_MAX;
                    res_st_reg  <= ST_DISABLED;
                end
            end
            S_SRD: begin
                res_val_reg <= '0;
                res_st_reg  <= ST_NO_CELL;
            end
            S_SCMP: begin
                n_reg      <= ncl_ext[NW-1:0];
                i_reg      <= '0;
                area_reg   <= '0;
                best_v_reg <= 1'b0;
                res_val_reg <= CLEAR_MAX;
                res_st_reg  <= ST_OK;
                if (!hit) begin
                    c_reg <= c_reg + LW'(1);
                end
            end
            S_ALD0, S_ELD0: begin
                ax_reg <= bx;
                ay_reg <= by;
            end
            S_AMUL: begin
                p1_reg <= mp1;
                p2_reg <= mp2;
                ax_reg <= bx;
                ay_reg <= by;
            end
            S_AACC: begin
                area_reg <= area_reg + AW'(p1_reg) - AW'(p2_reg);
                i_reg    <= last ? '0 : i_reg + NW'(1);
            end
            S_EDIF: begin
                dx_reg <= {bx[CW-1], bx} - {ax_reg[CW-1], ax_reg};
                dy_reg <= {by[CW-1], by} - {ay_reg[CW-1], ay_reg};
                ex_reg <= {ax_reg[CW-1], ax_reg} - {px_reg[CW-1], px_reg};
                ey_reg <= {ay_reg[CW-1], ay_reg} - {py_reg[CW-1], py_reg};
                ax_reg <= bx;
                ay_reg <= by;
            end
            S_EM1: begin
                p1_reg <= mp1;
                p2_reg <= mp2;
            end
            S_EM2: begin
                len2_reg <= {1'b0, p1_reg} + {1'b0, p2_reg};
                p1_reg   <= mp1;
                p2_reg   <= mp2;
            end
            S_EM3: begin
                cross_reg <= RW'(p1_reg) - RW'(p2_reg);
                rad_reg   <= (2 * SQW)'(len2_reg);
                srem_reg  <= '0;
                root_reg  <= '0;
                k_reg     <= KW'(SQW);
            end
            S_SQRT: if (k_reg != '0) begin
                rad_reg  <= {rad_reg[2*SQW-3:0], 2'b00};
                srem_reg <= srem_d[SQW:0];
                root_reg <= {root_reg[SQW-2:0], sq_ge};
                k_reg    <= k_reg - KW'(1);
            end
            S_DIVI: begin
                neg_reg  <= cross_reg[RW-1];
                num_reg  <= cross_mag;
                drem_reg <= '0;
                q_reg    <= '0;
                sat_reg  <= 1'b0;
                k_reg    <= KW'(MW);
            end
            S_DIV: if (k_reg != '0) begin
                num_reg  <= {num_reg[MW-2:0], 1'b0};
                drem_reg <= dsub[DIVW-1:0];
                q_reg    <= {q_reg[QW-2:0], dv_ge};
                sat_reg  <= sat_reg | q_reg[QW-1];
                k_reg    <= k_reg - KW'(1);
            end
            S_EACC: if (!best_v_reg || margin < best_reg) begin
                best_reg   <= margin;
                best_v_reg <= 1'b1;
            end
            S_ENEXT: begin
                i_reg <= i_reg + NW'(1);
                if (best_v_reg) begin
                    res_val_reg <= best_sat;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/convex_cell_clearance.sv =====
// Top level of the convex cell clearance block: register port and the three parts.
//
// Requests arrive on the s_ channel (valid/ready) and carry one of three
// commands: vertex write, cell interval and count write, or clearance query.
// Every write and every query returns exactly one result on the m_ channel;
// an unused command code is taken and produces nothing.
// The user must write registers over the APB-style port only while the block is
// idle; the block itself does not enforce this. A front end classifies each
// request into a two-entry queue, so a new request can be taken while the back
// end works or its result waits. A write is stored when the back end takes it
// from the queue; its result follows without further work. A query walks the
// cells one at a time, runs a winding pass over the vertices and then, per
// edge, 34 square root steps followed by 67 divide steps.
// The back end handles one request at a time; a stalled m_ready holds the
// result and back pressure reaches s_ready once the queue fills.
// Reset clears registers and control; cell stores are undefined until written.
module convex_cell_clearance import ccc_pkg::*; #(
    parameter int MAX_CELLS    = MAX_CELLS_DEF,
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [3:0]         s_cell_index,
    input  logic [2:0]         s_vertex_index,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_interval_begin,
    input  logic signed [31:0] s_interval_end,
    input  logic [3:0]         s_vertex_count,
    input  logic signed [31:0] s_query_progress,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_clearance_value,
    output logic [1:0]         m_status
);

    cfg_t  cfg_reg;
    logic  wr_en;
    logic  q_full, q_push, q_pop, q_valid;
    item_t push_item, pop_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                REG_ENABLE:    cfg_reg.region_enabled     <= pwdata[0];
                REG_RADIUS:    cfg_reg.robot_radius       <= pwdata[30:0];
                REG_MARGIN:    cfg_reg.safety_margin      <= pwdata[30:0];
                REG_TOLERANCE: cfg_reg.progress_tolerance <= pwdata[30:0];
                REG_CELLS:     cfg_reg.cells_in_use       <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_ENABLE:    prdata = {31'd0, cfg_reg.region_enabled};
            REG_RADIUS:    prdata = {1'b0, cfg_reg.robot_radius};
            REG_MARGIN:    prdata = {1'b0, cfg_reg.safety_margin};
            REG_TOLERANCE: prdata = {1'b0, cfg_reg.progress_tolerance};
            REG_CELLS:     prdata = {27'd0, cfg_reg.cells_in_use};
            default:       prdata = 32'd0;
        endcase
    end

    ccc_front u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_cell_index     (s_cell_index),
        .s_vertex_index   (s_vertex_index),
        .s_coord_x        (s_coord_x),
        .s_coord_y        (s_coord_y),
        .s_interval_begin (s_interval_begin),
        .s_interval_end   (s_interval_end),
        .s_vertex_count   (s_vertex_count),
        .s_query_progress (s_query_progress),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (push_item)
    );

    ccc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    ccc_back #(
        .MAX_CELLS    (MAX_CELLS),
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .q_valid           (q_valid),
        .q_item            (pop_item),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_clearance_value (m_clearance_value),
        .m_status          (m_status)
    );

endmodule

// ===== test/convex_cell_clearance_tb.sv =====
// Self-checking testbench for the convex cell clearance block.
module convex_cell_clearance_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ccc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int NUM_CELLS = 16;
    localparam int NUM_SLOTS = 8;
    localparam int SETTLE_CYCLES = 1500;
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef struct {
        logic [1:0]         cmd;
        logic [3:0]         cell_id;
        logic [2:0]         slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] ibegin;
        logic signed [31:0] iend;
        logic [3:0]         count;
        logic signed [31:0] progress;
    } request_t;

    typedef struct {
        logic signed [31:0] value;
        logic [1:0]         status;
    } answer_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = CMD_VERTEX;
    logic [3:0]         s_cell_index = '0;
    logic [2:0]         s_vertex_index = '0;
    logic signed [31:0] s_coord_x = '0;
    logic signed [31:0] s_coord_y = '0;
    logic signed [31:0] s_interval_begin = '0;
    logic signed [31:0] s_interval_end = '0;
    logic [3:0]         s_vertex_count = '0;
    logic signed [31:0] s_query_progress = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_clearance_value;
    logic [1:0]         m_status;

    convex_cell_clearance dut (.*);

    always #5 aclk = ~aclk;

    // Predictor state: stores and registers as the block should hold them.
    logic signed [31:0] cell_vx [NUM_CELLS][NUM_SLOTS];
    logic signed [31:0] cell_vy [NUM_CELLS][NUM_SLOTS];
    logic signed [31:0] cell_lo [NUM_CELLS];
    logic signed [31:0] cell_hi [NUM_CELLS];
    logic [3:0]         cell_count [NUM_CELLS];
    logic               reg_enable = 1'b0;
    logic [30:0]        reg_radius = '0;
    logic [30:0]        reg_margin = '0;
    logic [30:0]        reg_tolerance = '0;
    logic [4:0]         reg_cells = '0;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    int       error_count = 0;
    int       checked_count = 0;
    int       query_count = 0;
    int       pushed_count = 0;
    longint   cycle_count = 0;
    logic     s_taken = 1'b0;
    int       gap_left = 0;
    int       burst_left = 4;

    // Centre and size of the polygon last loaded into each cell, to aim queries.
    int cell_cx [NUM_CELLS];
    int cell_cy [NUM_CELLS];
    int cell_span [NUM_CELLS];
    int dir_x [8] = '{10, 7, 0, -7, -10, -7, 0, 7};
    int dir_y [8] = '{0, 7, 10, 7, 0, -7, -10, -7};

    function automatic logic [63:0] floor_sqrt(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] tw;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            tw = {64'd0, t};
            if (n >= tw * tw) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] cell_clearance(int c, logic signed [31:0] px,
                                                          logic signed [31:0] py);
        int n;
        int j;
        logic signed [127:0] ax, ay, bx, by, qx, qy, dx, dy, area, cr, best, edge_dist, m, infl;
        logic [127:0] mag, quot;
        logic [63:0]  len;
        logic         flip;
        logic         neg;
        n = (cell_count[c] > NUM_SLOTS) ? NUM_SLOTS : int'(cell_count[c]);
        qx = px;
        qy = py;
        area = '0;
        best = 128'sh7FFF_FFFF_FFFF_FFFF;
        infl = $signed({97'd0, reg_radius}) + $signed({97'd0, reg_margin});
        for (int i = 0; i < n; i++) begin
            j = (i + 1) % n;
            ax = cell_vx[c][i]; ay = cell_vy[c][i];
            bx = cell_vx[c][j]; by = cell_vy[c][j];
            area = area + ax * by - ay * bx;
        end
        flip = area < 0;
        for (int i = 0; i < n; i++) begin
            j = (i + 1) % n;
            ax = cell_vx[c][i]; ay = cell_vy[c][i];
            bx = cell_vx[c][j]; by = cell_vy[c][j];
            dx = bx - ax;
            dy = by - ay;
            len = floor_sqrt(dx * dx + dy * dy);
            if (len != 0) begin
                cr = dy * (ax - qx) - dx * (ay - qy);
                neg = cr < 0;
                mag = neg ? -cr : cr;
                quot = mag / {64'd0, len};
                if (quot > (128'd1 << 62)) quot = 128'd1 << 62;
                edge_dist = (neg != flip) ? -$signed(quot) : $signed(quot);
                m = edge_dist - infl;
                if (m < best) best = m;
            end
        end
        if (best > 128'sh7FFF_FFFF) return CLEAR_MAX;
        if (best < -128'sh8000_0000) return CLEAR_MIN;
        return best[31:0];
    endfunction

    task automatic predict_answer(request_t r);
        answer_t a;
        longint  prog;
        longint  tol;
        int      lim;
        a.value = '0;
        a.status = ST_WRITE;
        case (r.cmd)
            CMD_VERTEX: begin
                cell_vx[r.cell_id][r.slot] = r.x;
                cell_vy[r.cell_id][r.slot] = r.y;
            end
            CMD_INTERVAL: begin
                cell_lo[r.cell_id] = r.ibegin;
                cell_hi[r.cell_id] = r.iend;
                cell_count[r.cell_id] = r.count;
            end
            CMD_QUERY: begin
                query_count++;
                if (!reg_enable) begin
                    a.value = CLEAR_MAX;
                    a.status = ST_DISABLED;
                end else begin
                    prog = r.progress;
                    tol = longint'(reg_tolerance);
                    lim = (reg_cells > NUM_CELLS) ? NUM_CELLS : int'(reg_cells);
                    a.status = ST_NO_CELL;
                    for (int c = 0; c < lim; c++) begin
                        if (prog >= longint'(cell_lo[c]) - tol &&
                            prog <= longint'(cell_hi[c]) + tol) begin
                            a.value = cell_clearance(c, r.x, r.y);
                            a.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            default: return;
        endcase
        expected_answers = {expected_answers, a};
    endtask

    // Sender: bursts of requests separated by random gaps.
    always @(negedge aclk) begin
        request_t r;
        logic     nv;
        nv = s_valid;
        if (aresetn && (!s_valid || s_taken)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_requests.size() > 0) begin
                r = pending_requests.pop_front();
                s_command <= r.cmd;
                s_cell_index <= r.cell_id;
                s_vertex_index <= r.slot;
                s_coord_x <= r.x;
                s_coord_y <= r.y;
                s_interval_begin <= r.ibegin;
                s_interval_end <= r.iend;
                s_vertex_count <= r.count;
                s_query_progress <= r.progress;
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                end
            end
        end
        s_valid <= nv;
    end

    // Receiver: always ready, random stalls, or long stalls, in turn.
    always @(negedge aclk) begin
        case ((cycle_count / 300) % 3)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Take accepted requests into the predictor and check every result.
    always @(posedge aclk) begin
        request_t r;
        answer_t  e;
        s_taken = aresetn && s_valid && s_ready;
        if (s_taken) begin
            r.cmd = s_command; r.cell_id = s_cell_index; r.slot = s_vertex_index;
            r.x = s_coord_x; r.y = s_coord_y;
            r.ibegin = s_interval_begin; r.iend = s_interval_end;
            r.count = s_vertex_count; r.progress = s_query_progress;
            predict_answer(r);
        end
        if (aresetn && m_valid && m_ready) begin
            checked_count++;
            if (expected_answers.size() == 0) begin
                $error("result with no request waiting: clearance %0d status %0d",
                       m_clearance_value, m_status);
                error_count++;
            end else begin
                e = expected_answers.pop_front();
                if (m_clearance_value !== e.value) begin
                    $error("clearance_value expected %0d actual %0d", e.value,
                           m_clearance_value);
                    error_count++;
                end
                if (m_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, m_status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[convex_cell_clearance] ERROR");
            $finish;
        end
    end

    function automatic request_t random_request(logic [1:0] cmd);
        request_t r;
        r.cmd = cmd;
        r.cell_id = 4'($urandom);
        r.slot = 3'($urandom);
        r.x = $urandom;
        r.y = $urandom;
        r.ibegin = $urandom;
        r.iend = $urandom;
        r.count = 4'($urandom);
        r.progress = $urandom;
        return r;
    endfunction

    task automatic push_vertex(int c, int v, logic signed [31:0] x, logic signed [31:0] y);
        request_t r;
        r = random_request(CMD_VERTEX);
        r.cell_id = 4'(c); r.slot = 3'(v); r.x = x; r.y = y;
        pending_requests = {pending_requests, r};
        pushed_count++;
    endtask

    task automatic push_interval(int c, logic signed [31:0] b, logic signed [31:0] e,
                                 logic [3:0] n);
        request_t r;
        r = random_request(CMD_INTERVAL);
        r.cell_id = 4'(c); r.ibegin = b; r.iend = e; r.count = n;
        pending_requests = {pending_requests, r};
        pushed_count++;
    endtask

    task automatic push_query(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] p);
        request_t r;
        r = random_request(CMD_QUERY);
        r.x = x; r.y = y; r.progress = p;
        pending_requests = {pending_requests, r};
        pushed_count++;
    endtask

    // A convex polygon from a subset of octagon directions, either winding.
    task automatic load_polygon(int c);
        int n, left, slot, s, count;
        logic reversed;
        count = 0;
        n = $urandom_range(3, 8);
        if ($urandom_range(0, 5) == 0) begin
            n = 8;
            count = $urandom_range(9, 15);
        end
        reversed = 1'($urandom_range(0, 1));
        s = 1 << $urandom_range(10, 22);
        cell_cx[c] = int'($urandom_range(0, 1 << 29)) - (1 << 28);
        cell_cy[c] = int'($urandom_range(0, 1 << 29)) - (1 << 28);
        cell_span[c] = 12 * s;
        left = n;
        slot = 0;
        for (int k = 0; k < 8; k++) begin
            if ($urandom_range(1, 8 - k) <= left) begin
                push_vertex(c, reversed ? n - 1 - slot : slot,
                            cell_cx[c] + dir_x[k] * s, cell_cy[c] + dir_y[k] * s);
                slot++;
                left--;
            end
        end
        push_interval(c, c << 20, (c << 20) + (1 << 19), 4'((count != 0) ? count : n));
    endtask

    task automatic push_aimed_query();
        int c;
        c = $urandom_range(0, NUM_CELLS - 1);
        push_query(cell_cx[c] + int'($urandom_range(0, 2 * cell_span[c])) - cell_span[c],
                   cell_cy[c] + int'($urandom_range(0, 2 * cell_span[c])) - cell_span[c],
                   (c << 20) + int'($urandom_range(0, 1 << 20)) - (1 << 18));
    endtask

    task automatic push_random_mix(int total);
        int target;
        int pick;
        target = pushed_count + total;
        while (pushed_count < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                load_polygon($urandom_range(0, NUM_CELLS - 1));
            end else if (pick < 38) begin
                push_vertex($urandom_range(0, 15), $urandom_range(0, 7), $urandom, $urandom);
            end else if (pick < 44) begin
                push_interval($urandom_range(0, 15), $urandom, $urandom, 4'($urandom));
            end else if (pick < 48) begin
                pending_requests = {pending_requests, random_request(CMD_UNUSED)};
            end else if (pick < 52) begin
                push_query($urandom, $urandom, $urandom);
            end else begin
                push_aimed_query();
            end
        end
    endtask

    // Write one register, then read it back.
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        logic [31:0] readback;
        readback = '0;
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_ENABLE: begin
                reg_enable = val[0];
                readback = {31'd0, val[0]};
            end
            REG_RADIUS: begin
                reg_radius = val[30:0];
                readback = {1'b0, val[30:0]};
            end
            REG_MARGIN: begin
                reg_margin = val[30:0];
                readback = {1'b0, val[30:0]};
            end
            REG_TOLERANCE: begin
                reg_tolerance = val[30:0];
                readback = {1'b0, val[30:0]};
            end
            REG_CELLS: begin
                reg_cells = val[4:0];
                readback = {27'd0, val[4:0]};
            end
            default: ;
        endcase
        @(negedge aclk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (!pready || prdata !== readback) begin
            $error("prdata expected %0h actual %0h", readback, prdata);
            error_count++;
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only once every request has been answered and the block settled.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || s_valid || expected_answers.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_registers(logic [31:0] en, logic [31:0] rad, logic [31:0] mar,
                                 logic [31:0] tol, logic [31:0] cells);
        reg_write(REG_ENABLE, en);
        reg_write(REG_RADIUS, rad);
        reg_write(REG_MARGIN, mar);
        reg_write(REG_TOLERANCE, tol);
        reg_write(REG_CELLS, cells);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Fill every slot of every cell so that no query reads an unwritten entry.
        for (int c = 0; c < NUM_CELLS; c++) begin
            for (int v = 0; v < NUM_SLOTS; v++) push_vertex(c, v, $urandom, $urandom);
            load_polygon(c);
        end
        // Cell 13 spans the whole coordinate range, cell 14 has no vertices,
        // cell 15 has every vertex on one point and a count above the slot number.
        push_vertex(13, 0, 32'sh8000_0000, 32'sh8000_0000);
        push_vertex(13, 1, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_vertex(13, 2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_vertex(13, 3, 32'sh8000_0000, 32'sh7FFF_FFFF);
        push_interval(13, 13 << 20, (13 << 20) + (1 << 19), 4);
        push_interval(14, 14 << 20, (14 << 20) + (1 << 19), 0);
        for (int v = 0; v < NUM_SLOTS; v++) push_vertex(15, v, 5, 5);
        push_interval(15, 15 << 20, (15 << 20) + (1 << 19), 15);
        push_query(0, 0, 0);
        push_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        wait_idle();

        set_registers(32'h1, 0, 0, 0, NUM_CELLS);
        push_query(cell_cx[0], cell_cy[0], 0);
        push_query(cell_cx[5], cell_cy[5], (5 << 20) + (1 << 19));
        push_query(0, 0, 13 << 20);
        push_query(32'sh7FFF_FFFF, 32'sh8000_0000, 13 << 20);
        push_query(32'sh8000_0000, 32'sh7FFF_FFFF, 13 << 20);
        push_query(cell_cx[3], cell_cy[3], 14 << 20);
        push_query(5, 5, 15 << 20);
        push_query(0, 0, 32'sh8000_0000);
        push_query(0, 0, 32'sh7FFF_FFFF);
        pending_requests = {pending_requests, random_request(CMD_UNUSED)};
        push_query(cell_cx[2], cell_cy[2], (2 << 20) + (1 << 19) + 1);
        push_random_mix(140);
        wait_idle();

        set_registers(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        push_random_mix(35);
        wait_idle();

        reg_write(REG_CELLS, 32'h1F);
        push_random_mix(55);
        wait_idle();

        set_registers(32'h1, $urandom_range(0, 1 << 22), $urandom_range(0, 1 << 20),
                      $urandom_range(0, 1 << 19), $urandom_range(1, 16));
        push_random_mix(170);
        wait_idle();

        set_registers(32'hFFFF_FFFE, $urandom, $urandom, $urandom, $urandom);
        push_random_mix(30);
        wait_idle();

        $display("Checked %0d results, %0d of them queries, under six register settings",
                 checked_count, query_count);
        $display("including disabled, no-cell, saturating and degenerate-cell cases");
        if (error_count == 0) begin
            $display("[convex_cell_clearance] OK");
        end else begin
            $display("[convex_cell_clearance] ERROR");
        end
        $finish;
    end

endmodule
